// ===== hw/rtl/heat_alarm_sample_qualifier_core_macros.svh =====
// ============================================================================
// Heat alarm sample qualifier assertion macros
// Shared concurrent assertion forms, clocked on aclk and held off in reset.
// ============================================================================
`ifndef HEAT_ALARM_SAMPLE_QUALIFIER_CORE_MACROS_SVH
`define HEAT_ALARM_SAMPLE_QUALIFIER_CORE_MACROS_SVH

// Same-cycle implication.
`define HASQ_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define HASQ_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |=> (cons)) else $error(msg);

`endif

// ===== hw/rtl/hasq_pkg.sv =====
// ============================================================================
// Heat alarm sample qualifier package
// Shared types, register map, thermistor table and the reading-to-degrees map.
// ============================================================================
`default_nettype none

package hasq_pkg;

    // Thermistor table geometry.
    localparam int TABLE_LEN  = 84;
    localparam int DEG_W      = 7;
    localparam int SAMPLE_W   = 8;
    localparam int LUT_DEPTH  = 256;

    // Out-of-range reading limits for the fault history.
    localparam logic [SAMPLE_W-1:0] FAULT_HIGH = 8'd250;
    localparam logic [SAMPLE_W-1:0] FAULT_LOW  = 8'd5;

    // History widths and full patterns.
    localparam int FAULT_HIST_W = 8;
    localparam int OVER_HIST_W  = 3;
    localparam logic [FAULT_HIST_W-1:0] FAULT_HIST_FULL = 8'hFF;
    localparam logic [OVER_HIST_W-1:0]  OVER_HIST_FULL  = 3'h7;
    localparam logic [OVER_HIST_W-1:0]  OVER_HIST_NONE  = 3'h0;

    // Configuration port: register index sits in paddr[2].
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam logic REG_ALARM_TEMP = 1'b0;
    localparam logic [SAMPLE_W-1:0] ALARM_TEMP_RESET = 8'd60;

    // Descending converter readings, one per degree.
    typedef logic [0:TABLE_LEN-1][SAMPLE_W-1:0] ntc_table_t;
    localparam ntc_table_t NTC_TABLE = '{
        8'd222, 8'd221, 8'd219, 8'd218, 8'd216, 8'd215, 8'd213, 8'd211, 8'd209,
        8'd207, 8'd206, 8'd204, 8'd202, 8'd200, 8'd198, 8'd195, 8'd193, 8'd191,
        8'd189, 8'd187, 8'd184, 8'd182, 8'd180, 8'd177, 8'd175, 8'd172, 8'd170,
        8'd167, 8'd165, 8'd162, 8'd160, 8'd157, 8'd155, 8'd152, 8'd149, 8'd147,
        8'd144, 8'd142, 8'd139, 8'd137, 8'd134, 8'd131, 8'd129, 8'd126, 8'd124,
        8'd121, 8'd119, 8'd116, 8'd114, 8'd111, 8'd109, 8'd107, 8'd104, 8'd102,
        8'd100, 8'd97,  8'd95,  8'd93,  8'd91,  8'd89,  8'd87,  8'd85,  8'd83,
        8'd81,  8'd79,  8'd77,  8'd75,  8'd73,  8'd71,  8'd69,  8'd68,  8'd66,
        8'd64,  8'd63,  8'd61,  8'd60,  8'd58,  8'd57,  8'd55,  8'd54,  8'd52,
        8'd51,  8'd50,  8'd49
    };

    localparam logic [DEG_W-1:0] DEG_MAX = DEG_W'(TABLE_LEN - 1);

    // Full reading-to-degrees map, one entry per reading.
    typedef logic [0:LUT_DEPTH-1][DEG_W-1:0] deg_lut_t;

    // Built once at elaboration from the descending table.
    function automatic deg_lut_t build_deg_lut();
        deg_lut_t lut;
        logic     found;
        for (int r = 0; r < LUT_DEPTH; r++) begin
            found  = 1'b0;
            lut[r] = DEG_MAX;
            if (r > int'(NTC_TABLE[0])) begin
                lut[r] = '0;
            end else if (r >= int'(NTC_TABLE[TABLE_LEN-1])) begin
                for (int i = 0; i < TABLE_LEN; i++) begin
                    if (!found && r >= int'(NTC_TABLE[i])) begin
                        lut[r] = DEG_W'(i);
                        found  = 1'b1;
                    end
                end
            end
        end
        return lut;
    endfunction

    localparam deg_lut_t DEG_LUT = build_deg_lut();

    // Input transfer payload.
    typedef struct packed {
        logic [SAMPLE_W-1:0] adc_sample;
        logic                clear_alarm;
    } in_item_t;

    // Result transfer payload.
    typedef struct packed {
        logic [DEG_W-1:0] temperature;
        logic             over_threshold;
        logic             sensor_fault;
        logic             fire_alarm;
        logic             exit_pending;
    } out_item_t;

    // Conversion results handed to the history logic.
    typedef struct packed {
        logic [DEG_W-1:0] temperature;
        logic             over_threshold;
        logic             out_of_range;
    } conv_t;

    // Sticky flag values after one sample.
    typedef struct packed {
        logic sensor_fault;
        logic fire_alarm;
        logic exit_pending;
    } flags_t;

endpackage

`default_nettype wire

// ===== hw/rtl/heat_alarm_sample_qualifier_core.sv =====
// ============================================================================
// Heat alarm sample qualifier core
// Converts thermistor readings to degrees and qualifies fault and fire alarms.
// ============================================================================
//
//  Channel   Ports               Carries
//  -------   -----------------   ------------------------------------------
//  s_        s_valid/s_ready     in_item_t: adc_sample, clear_alarm
//  m_        m_valid/m_ready     out_item_t: temperature and status flags
//  apb       psel..pready        alarm_temp threshold at byte address 0
//
//  One transfer is accepted per cycle while the result side keeps up; a
//  result passes the input register and then the result register before
//  it is offered.
//  The table lookup, compares and history update sit between those two.
//  Reset is synchronous, active low, and clears histories, flags and valids.
//  A stalled result holds; one more sample waits in the input register,
//  and then s_ready drops until the result transfers.
//
`default_nettype none

`include "heat_alarm_sample_qualifier_core_macros.svh"

module heat_alarm_sample_qualifier_core (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            s_valid,
    output logic                                 s_ready,
    input  wire hasq_pkg::in_item_t              s_data,
    output logic                                 m_valid,
    input  wire logic                            m_ready,
    output hasq_pkg::out_item_t                  m_data,
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [hasq_pkg::APB_ADDR_W-1:0] paddr,
    input  wire logic [hasq_pkg::APB_DATA_W-1:0] pwdata,
    output logic      [hasq_pkg::APB_DATA_W-1:0] prdata,
    output logic                                 pready
);
    import hasq_pkg::*;

    logic                in_valid_reg, in_valid_next;
    in_item_t            in_item_reg;
    logic                out_valid_reg, out_valid_next;
    out_item_t           out_item_reg, out_item_next;
    logic                advance;
    logic [SAMPLE_W-1:0] alarm_temp;
    conv_t               conv;
    flags_t              flags_next;

    // Threshold register port.
    hasq_cfg_regs u_cfg (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .alarm_temp (alarm_temp)
    );

    // Degrees, threshold and fault-limit checks.
    hasq_convert u_convert (
        .adc_sample (in_item_reg.adc_sample),
        .alarm_temp (alarm_temp),
        .conv       (conv)
    );

    // Histories and sticky flags.
    hasq_history u_history (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .update      (advance),
        .clear_alarm (in_item_reg.clear_alarm),
        .conv        (conv),
        .flags_next  (flags_next)
    );

    // A held sample moves on when the result register is free or draining.
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    // Valid bookkeeping for both registers and the next result.
    always_comb begin
        in_valid_next  = in_valid_reg;
        out_valid_next = out_valid_reg;
        if (s_valid && s_ready) begin
            in_valid_next = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end
        if (advance) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
        out_item_next.temperature    = conv.temperature;
        out_item_next.over_threshold = conv.over_threshold;
        out_item_next.sensor_fault   = flags_next.sensor_fault;
        out_item_next.fire_alarm     = flags_next.fire_alarm;
        out_item_next.exit_pending   = flags_next.exit_pending;
    end

    // Input register and result register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
        if (s_valid && s_ready) begin
            in_item_reg <= s_data;
        end
        if (advance) begin
            out_item_reg <= out_item_next;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_item_reg;

    // An empty input register always takes a transfer.
    `HASQ_ASSERT_NOW(a_empty_ready, !in_valid_reg, s_ready, "input stalled while empty")
    // A sample that moves on is shown as a result in the next cycle.
    `HASQ_ASSERT_NEXT(a_advance_out, advance, m_valid, "advanced sample not shown")
    // Temperatures stay inside the table.
    `HASQ_ASSERT_NOW(a_temp_range, m_valid, m_data.temperature <= DEG_MAX,
        "temperature beyond table")

endmodule

`default_nettype wire

// ===== hw/rtl/hasq_cfg_regs.sv =====
// ============================================================================
// Heat alarm sample qualifier configuration registers
// APB-style register port holding the alarm temperature threshold.
// ============================================================================
`default_nettype none

module hasq_cfg_regs (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [hasq_pkg::APB_ADDR_W-1:0] paddr,
    input  wire logic [hasq_pkg::APB_DATA_W-1:0] pwdata,
    output logic      [hasq_pkg::APB_DATA_W-1:0] prdata,
    output logic                                 pready,
    output logic      [hasq_pkg::SAMPLE_W-1:0]   alarm_temp
);
    import hasq_pkg::*;

    logic [SAMPLE_W-1:0] alarm_temp_val_reg;
    logic                wr_en;

    // No wait states.
    assign pready = 1'b1;

    // A write completes in the access phase.
    assign wr_en = psel && penable && pwrite && pready;

    // Threshold register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            alarm_temp_val_reg <= ALARM_TEMP_RESET;
        end else begin
            if (wr_en && paddr[2] == REG_ALARM_TEMP) begin
                alarm_temp_val_reg <= pwdata[SAMPLE_W-1:0];
            end
        end
    end

    assign alarm_temp = alarm_temp_val_reg;

    // Read-back mux; unmapped addresses read as zero.
    always_comb begin
        prdata = '0;
        if (paddr[2] == REG_ALARM_TEMP) begin
            prdata = {{(APB_DATA_W-SAMPLE_W){1'b0}}, alarm_temp_val_reg};
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/hasq_convert.sv =====
// ============================================================================
// Heat alarm sample qualifier conversion
// Maps a reading to degrees, checks the threshold and the fault limits.
// ============================================================================
`default_nettype none

module hasq_convert (
    input  wire logic [hasq_pkg::SAMPLE_W-1:0] adc_sample,
    input  wire logic [hasq_pkg::SAMPLE_W-1:0] alarm_temp,
    output hasq_pkg::conv_t                    conv
);
    import hasq_pkg::*;

    logic [DEG_W-1:0] deg;

    // Constant table lookup, one entry per reading.
    assign deg = DEG_LUT[adc_sample];

    // Degrees against threshold and readings against the fault limits.
    always_comb begin
        conv.temperature    = deg;
        conv.over_threshold = {1'b0, deg} > alarm_temp;
        conv.out_of_range   = (adc_sample >= FAULT_HIGH) || (adc_sample <= FAULT_LOW);
    end

endmodule

`default_nettype wire

// ===== hw/rtl/hasq_history.sv =====
// ============================================================================
// Heat alarm sample qualifier history
// Fault and over-threshold shift histories with their sticky flags.
// ============================================================================
`default_nettype none

`include "heat_alarm_sample_qualifier_core_macros.svh"

module hasq_history (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            update,
    input  wire logic            clear_alarm,
    input  wire hasq_pkg::conv_t conv,
    output hasq_pkg::flags_t     flags_next
);
    import hasq_pkg::*;

    logic [FAULT_HIST_W-1:0] fault_hist_reg, fault_hist_next;
    logic [OVER_HIST_W-1:0]  over_hist_reg,  over_hist_next;
    logic                    fault_reg, fire_reg, exit_reg;

    // Shift in this sample and derive the flags after it.
    always_comb begin
        fault_hist_next = {fault_hist_reg[FAULT_HIST_W-2:0], conv.out_of_range};
        over_hist_next  = {over_hist_reg[OVER_HIST_W-2:0], conv.over_threshold};
        flags_next.sensor_fault = fault_reg || (fault_hist_next == FAULT_HIST_FULL);
        flags_next.fire_alarm   = (fire_reg && !clear_alarm)
                                  || (over_hist_next == OVER_HIST_FULL);
        flags_next.exit_pending = (exit_reg && !clear_alarm)
                                  || (over_hist_next == OVER_HIST_NONE);
    end

    // State advances once per sample that moves to the result register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fault_hist_reg <= '0;
            over_hist_reg  <= '0;
            fault_reg      <= 1'b0;
            fire_reg       <= 1'b0;
            exit_reg       <= 1'b0;
        end else if (update) begin
            fault_hist_reg <= fault_hist_next;
            over_hist_reg  <= over_hist_next;
            fault_reg      <= flags_next.sensor_fault;
            fire_reg       <= flags_next.fire_alarm;
            exit_reg       <= flags_next.exit_pending;
        end
    end

    // The sensor fault never clears once set.
    `HASQ_ASSERT_NEXT(a_fault_sticky, fault_reg, fault_reg, "sensor fault dropped")
    // Fire sets only after three hits in a row.
    `HASQ_ASSERT_NOW(a_fire_rise, $rose(fire_reg), over_hist_reg == OVER_HIST_FULL,
        "fire alarm set without three hits")
    // Exit sets only after three misses in a row.
    `HASQ_ASSERT_NOW(a_exit_rise, $rose(exit_reg), over_hist_reg == OVER_HIST_NONE,
        "exit pending set without three misses")

endmodule

`default_nettype wire

// ===== sim/tb_heat_alarm_sample_qualifier_core.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Heat alarm sample qualifier core testbench
// Drives thermistor readings over the input channel and predicts every result
// with an independent table search and alarm history model. The alarm
// threshold is reprogrammed between phases, and both channel sides idle at
// random. One long hold-off on the result side backs up the input channel.
// ----------------------------------------------------------------------------
module tb_heat_alarm_sample_qualifier_core;
    import hasq_pkg::*;

    // Converter reading at each whole degree, hottest readings last.
    localparam logic [0:83][7:0] READING_AT_DEGREE = {
        8'd222, 8'd221, 8'd219, 8'd218, 8'd216, 8'd215, 8'd213, 8'd211, 8'd209,
        8'd207, 8'd206, 8'd204, 8'd202, 8'd200, 8'd198, 8'd195, 8'd193, 8'd191,
        8'd189, 8'd187, 8'd184, 8'd182, 8'd180, 8'd177, 8'd175, 8'd172, 8'd170,
        8'd167, 8'd165, 8'd162, 8'd160, 8'd157, 8'd155, 8'd152, 8'd149, 8'd147,
        8'd144, 8'd142, 8'd139, 8'd137, 8'd134, 8'd131, 8'd129, 8'd126, 8'd124,
        8'd121, 8'd119, 8'd116, 8'd114, 8'd111, 8'd109, 8'd107, 8'd104, 8'd102,
        8'd100, 8'd97,  8'd95,  8'd93,  8'd91,  8'd89,  8'd87,  8'd85,  8'd83,
        8'd81,  8'd79,  8'd77,  8'd75,  8'd73,  8'd71,  8'd69,  8'd68,  8'd66,
        8'd64,  8'd63,  8'd61,  8'd60,  8'd58,  8'd57,  8'd55,  8'd54,  8'd52,
        8'd51,  8'd50,  8'd49
    };
    localparam logic [6:0] HOTTEST_DEGREE = 7'd83;
    localparam logic [7:0] SHORTED_LIMIT  = 8'd250;
    localparam logic [7:0] OPEN_LIMIT     = 8'd5;
    localparam logic [APB_ADDR_W-1:0] ALARM_TEMP_ADDR = {REG_ALARM_TEMP, 2'b00};
    localparam int ITEMS_PER_PHASE = 125;
    localparam int LONG_HOLD_CYCLES = 64;
    localparam int PRINT_LIMIT = 100;

    // Directed readings as {clear_alarm, adc_sample}.
    localparam logic [0:23][8:0] DIRECTED_SAMPLES = {
        {1'b0, 8'd255}, {1'b0, 8'd0},   {1'b0, 8'd250}, {1'b0, 8'd5},
        {1'b0, 8'd254}, {1'b0, 8'd1},   {1'b0, 8'd253}, {1'b0, 8'd6},
        {1'b0, 8'd249}, {1'b0, 8'd48},  {1'b0, 8'd49},  {1'b0, 8'd50},
        {1'b0, 8'd222}, {1'b0, 8'd223}, {1'b0, 8'd221}, {1'b0, 8'd87},
        {1'b0, 8'd85},  {1'b0, 8'd50},  {1'b0, 8'd50},  {1'b1, 8'd50},
        {1'b0, 8'd200}, {1'b0, 8'd200}, {1'b0, 8'd200}, {1'b1, 8'd200}
    };

    typedef enum int { RUN_HOT, RUN_COLD, RUN_OUT_OF_RANGE, RUN_ANY } sample_run_e;

    logic        aclk    = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    in_item_t    s_data  = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    out_item_t   m_data;
    logic        psel    = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite  = 1'b0;
    logic [APB_ADDR_W-1:0] paddr  = '0;
    logic [APB_DATA_W-1:0] pwdata = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic        pready;

    // Predicted block state and threshold.
    logic [7:0]  alarm_threshold = 8'd60;
    logic [7:0]  range_history   = '0;
    logic        fault_seen      = 1'b0;
    logic [2:0]  heat_history    = '0;
    logic        fire_seen       = 1'b0;
    logic        exit_seen       = 1'b0;

    in_item_t    sample_backlog[$];
    out_item_t   expected_status[$];
    int          samples_queued   = 0;
    int          samples_accepted = 0;
    int          mismatch_count   = 0;
    int          gap_left         = 0;
    int          stall_left       = 0;
    int          long_hold_left   = 0;
    logic        long_hold_armed  = 1'b0;
    logic        long_hold_done   = 1'b0;
    logic        quiet_tail       = 1'b0;

    heat_alarm_sample_qualifier_core i_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    initial begin
        forever #1 aclk = ~aclk;
    end

    initial begin
        #400000;
        $display("[FAIL] regression broken");
        $finish;
    end

    task automatic report_mismatch(string msg);
        mismatch_count++;
        if (mismatch_count <= PRINT_LIMIT) begin
            $display("%0t ns: %s", $time, msg);
        end
    endtask

    // Descending table search; readings colder than entry 0 give 0 degrees.
    function automatic logic [6:0] degrees_of(logic [7:0] reading);
        if (reading > READING_AT_DEGREE[0]) begin
            return '0;
        end
        for (int i = 0; i < 84; i++) begin
            if (reading >= READING_AT_DEGREE[i]) begin
                return 7'(i);
            end
        end
        return HOTTEST_DEGREE;
    endfunction

    // Update the predicted histories for one accepted sample.
    task automatic qualify_sample(in_item_t item);
        out_item_t status;
        logic [6:0] degrees;
        logic hot;
        if (item.clear_alarm) begin
            fire_seen = 1'b0;
            exit_seen = 1'b0;
        end
        range_history = {range_history[6:0],
                         (item.adc_sample >= SHORTED_LIMIT) || (item.adc_sample <= OPEN_LIMIT)};
        if (range_history == 8'hFF) begin
            fault_seen = 1'b1;
        end
        degrees = degrees_of(item.adc_sample);
        hot = {1'b0, degrees} > alarm_threshold;
        heat_history = {heat_history[1:0], hot};
        if (heat_history == 3'b111) begin
            fire_seen = 1'b1;
        end
        if (heat_history == 3'b000) begin
            exit_seen = 1'b1;
        end
        status.temperature    = degrees;
        status.over_threshold = hot;
        status.sensor_fault   = fault_seen;
        status.fire_alarm     = fire_seen;
        status.exit_pending   = exit_seen;
        expected_status.push_back(status);
    endtask

    task automatic queue_sample(logic [7:0] reading, logic clear);
        in_item_t item;
        item.adc_sample  = reading;
        item.clear_alarm = clear;
        sample_backlog.push_back(item);
        samples_queued++;
    endtask

    // Runs of hot or cold readings relative to the threshold reach the alarm
    // flags; out-of-range runs and uniform noise are mixed in.
    task automatic queue_random_samples(int count, logic [7:0] threshold);
        int left;
        int run;
        int pick;
        sample_run_e kind;
        logic [7:0] reading;
        left = count;
        while (left > 0) begin
            pick = $urandom_range(0, 9);
            kind = (pick < 4) ? RUN_HOT : (pick < 8) ? RUN_COLD :
                   (pick == 8) ? RUN_OUT_OF_RANGE : RUN_ANY;
            if (threshold >= 8'(HOTTEST_DEGREE) && kind != RUN_OUT_OF_RANGE) begin
                kind = RUN_ANY;
            end
            run = $urandom_range(1, 9);
            for (int i = 0; i < run && left > 0; i++) begin
                case (kind)
                    RUN_HOT: begin
                        reading = 8'($urandom_range(6, READING_AT_DEGREE[threshold + 1]));
                    end
                    RUN_COLD: begin
                        reading = 8'($urandom_range(READING_AT_DEGREE[threshold], 249));
                    end
                    RUN_OUT_OF_RANGE: begin
                        reading = $urandom_range(0, 1) ? 8'($urandom_range(250, 255))
                                                       : 8'($urandom_range(0, 5));
                    end
                    default: begin
                        reading = 8'($urandom_range(0, 255));
                    end
                endcase
                queue_sample(reading, $urandom_range(0, 7) == 0);
                left--;
            end
        end
    endtask

    // Write the threshold, then read it back.
    task automatic set_alarm_temp(logic [7:0] value);
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ALARM_TEMP_ADDR;
        pwdata  <= APB_DATA_W'(value);
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        alarm_threshold = value;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        if (prdata[7:0] !== value) begin
            report_mismatch($sformatf("alarm_temp read back %0d, wrote %0d",
                                      prdata[7:0], value));
        end
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Wait until every queued sample is taken and every result has come.
    task automatic drain_results();
        while (samples_accepted != samples_queued || expected_status.size() != 0) begin
            @(posedge aclk);
        end
        repeat (4) @(posedge aclk);
    endtask

    // Input side: predict on each transfer, then offer the next sample.
    always @(posedge aclk) begin : sample_feeder
        logic offer;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                qualify_sample(s_data);
                samples_accepted++;
            end
            offer = s_valid && !s_ready;
            if (!offer && sample_backlog.size() != 0) begin
                if (gap_left > 0) begin
                    gap_left--;
                end else if (!quiet_tail && $urandom_range(0, 5) == 0) begin
                    gap_left = $urandom_range(0, 6);
                end else begin
                    s_data <= sample_backlog.pop_front();
                    offer = 1'b1;
                end
            end
            s_valid <= offer;
        end
    end

    // Result side: check each transfer, then choose ready for the next cycle.
    always @(posedge aclk) begin : status_checker
        out_item_t want;
        logic take;
        if (aresetn && m_valid && m_ready) begin
            if (expected_status.size() == 0) begin
                report_mismatch("result transfer with no sample pending");
            end else begin
                want = expected_status.pop_front();
                if (m_data.temperature !== want.temperature) begin
                    report_mismatch($sformatf("temperature got %0d expected %0d",
                                              m_data.temperature, want.temperature));
                end
                if (m_data.over_threshold !== want.over_threshold) begin
                    report_mismatch($sformatf("over_threshold got %b expected %b",
                                              m_data.over_threshold, want.over_threshold));
                end
                if (m_data.sensor_fault !== want.sensor_fault) begin
                    report_mismatch($sformatf("sensor_fault got %b expected %b",
                                              m_data.sensor_fault, want.sensor_fault));
                end
                if (m_data.fire_alarm !== want.fire_alarm) begin
                    report_mismatch($sformatf("fire_alarm got %b expected %b",
                                              m_data.fire_alarm, want.fire_alarm));
                end
                if (m_data.exit_pending !== want.exit_pending) begin
                    report_mismatch($sformatf("exit_pending got %b expected %b",
                                              m_data.exit_pending, want.exit_pending));
                end
            end
        end
        if (long_hold_armed && !long_hold_done) begin
            long_hold_left = LONG_HOLD_CYCLES;
            long_hold_done = 1'b1;
        end
        take = 1'b1;
        if (long_hold_left > 0) begin
            long_hold_left--;
            take = 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            take = 1'b0;
        end else if (!quiet_tail && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(0, 6);
            take = 1'b0;
        end
        m_ready <= take && aresetn;
    end

    initial begin
        logic [7:0] phase_temp [8];
        phase_temp[0] = 8'd0;
        phase_temp[1] = 8'd83;
        phase_temp[2] = 8'd82;
        phase_temp[3] = 8'($urandom_range(0, 255));
        phase_temp[4] = 8'd255;
        phase_temp[5] = 8'd1;
        phase_temp[6] = 8'($urandom_range(0, 82));
        phase_temp[7] = 8'd60;

        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed part at the reset threshold: out-of-range runs, table
        // ends, three hits and three misses, and clears that refire at once.
        set_alarm_temp(8'd60);
        for (int i = 0; i < 24; i++) begin
            queue_sample(DIRECTED_SAMPLES[i][7:0], DIRECTED_SAMPLES[i][8]);
        end
        drain_results();

        // Random phases at several thresholds, the extremes among them.
        for (int p = 0; p < 8; p++) begin
            set_alarm_temp(phase_temp[p]);
            quiet_tail = (p == 7);
            if (p == 2) begin
                long_hold_armed <= 1'b1;
            end
            queue_random_samples(ITEMS_PER_PHASE, phase_temp[p]);
            drain_results();
        end

        repeat (8) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
